[design/mtk_pkg.sv]
// Shared types, constants and the letter glyph table of the Morse tone keyer.
`default_nettype none

package mtk_pkg;

  localparam int unsigned LETTER_COUNT = 26;
  localparam int unsigned IDX_W        = $clog2(LETTER_COUNT);
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned HALF_W       = 16;
  localparam int unsigned PER_W        = 16;
  localparam int unsigned GAP_W        = 20;

  localparam logic [7:0] CHAR_A   = 8'h61;
  localparam logic [7:0] CHAR_END = 8'(97 + LETTER_COUNT);

  localparam logic [HALF_W-1:0] RST_TONE_HALF    = 16'd106;
  localparam logic [PER_W-1:0]  RST_DOT_PERIODS  = 16'd471;
  localparam logic [PER_W-1:0]  RST_DASH_PERIODS = 16'd1179;
  localparam logic [GAP_W-1:0]  RST_ELEMENT_GAP  = 20'd200000;
  localparam logic [GAP_W-1:0]  RST_LETTER_GAP   = 20'd500000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TONE_HALF    = 3'd0,
    CFG_DOT_PERIODS  = 3'd1,
    CFG_DASH_PERIODS = 3'd2,
    CFG_ELEMENT_GAP  = 3'd3,
    CFG_LETTER_GAP   = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_TONE = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [HALF_W-1:0] tone_half_period;
    logic [PER_W-1:0]  dot_periods;
    logic [PER_W-1:0]  dash_periods;
    logic [GAP_W-1:0]  element_gap;
    logic [GAP_W-1:0]  letter_gap;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic       enabled;
  } item_t;

  typedef struct packed {
    logic speaker;
    logic busy_res;
    logic char_done;
    logic rejected;
  } res_t;

  // Top three bits: element count; low bits: elements, 1 = dash.
  function automatic logic [7:0] mtk_glyph(input logic [IDX_W-1:0] idx);
    logic [7:0] g;
    g = 8'h00;
    unique case (idx)
      5'd0:  g = 8'h41;
      5'd1:  g = 8'h88;
      5'd2:  g = 8'h8A;
      5'd3:  g = 8'h64;
      5'd4:  g = 8'h20;
      5'd5:  g = 8'h82;
      5'd6:  g = 8'h66;
      5'd7:  g = 8'h80;
      5'd8:  g = 8'h40;
      5'd9:  g = 8'h87;
      5'd10: g = 8'h65;
      5'd11: g = 8'h84;
      5'd12: g = 8'h43;
      5'd13: g = 8'h42;
      5'd14: g = 8'h67;
      5'd15: g = 8'h86;
      5'd16: g = 8'h8D;
      5'd17: g = 8'h62;
      5'd18: g = 8'h60;
      5'd19: g = 8'h21;
      5'd20: g = 8'h61;
      5'd21: g = 8'h81;
      5'd22: g = 8'h63;
      5'd23: g = 8'h89;
      5'd24: g = 8'h8B;
      5'd25: g = 8'h8C;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[design/mtk_if.sv]
// Valid/ready channel interfaces for items, results and configuration writes.
`default_nettype none

interface mtk_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;
  logic       enabled;

  modport source (output valid, output req_type, output char_code, output enabled,
                  input ready);
  modport sink   (input valid, input req_type, input char_code, input enabled,
                  output ready);
endinterface

interface mtk_out_if;
  logic valid;
  logic ready;
  logic speaker;
  logic busy_res;
  logic char_done;
  logic rejected;

  modport source (output valid, output speaker, output busy_res, output char_done,
                  output rejected, input ready);
  modport sink   (input valid, input speaker, input busy_res, input char_done,
                  input rejected, output ready);
endinterface

interface mtk_cfg_if
  import mtk_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/mtk_cfg_regs.sv]
// Configuration register file of the Morse tone keyer.
`default_nettype none

module mtk_cfg_regs
  import mtk_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mtk_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_TONE_HALF:    cfg_d.tone_half_period = cfg_i.data[HALF_W-1:0];
        CFG_DOT_PERIODS:  cfg_d.dot_periods      = cfg_i.data[PER_W-1:0];
        CFG_DASH_PERIODS: cfg_d.dash_periods     = cfg_i.data[PER_W-1:0];
        CFG_ELEMENT_GAP:  cfg_d.element_gap      = cfg_i.data[GAP_W-1:0];
        CFG_LETTER_GAP:   cfg_d.letter_gap       = cfg_i.data[GAP_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tone_half_period <= RST_TONE_HALF;
      cfg_q.dot_periods      <= RST_DOT_PERIODS;
      cfg_q.dash_periods     <= RST_DASH_PERIODS;
      cfg_q.element_gap      <= RST_ELEMENT_GAP;
      cfg_q.letter_gap       <= RST_LETTER_GAP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/mtk_core.sv]
// Keyer state machine: one tick or submission per step, result for that step.
`default_nettype none

module mtk_core
  import mtk_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  input  wire logic  step_i,
  input  item_t      item_i,
  output res_t       res_o
);

  phase_e            phase_q, phase_d;
  logic [IDX_W-1:0]  letter_q, letter_d;
  logic [2:0]        pos_q, pos_d;
  logic [HALF_W-1:0] half_q, half_d;
  logic [PER_W-1:0]  per_q, per_d;
  logic [GAP_W-1:0]  gap_q, gap_d;
  logic              pin_q, pin_d;
  logic              final_q, final_d;

  logic [7:0]        glyph_cur;
  logic [7:0]        glyph_new;
  logic [7:0]        ch_off;
  logic              is_letter;
  logic [PER_W-1:0]  elem_periods;
  logic [HALF_W-1:0] half_inc;
  logic [PER_W-1:0]  per_inc;
  logic [GAP_W-1:0]  gap_dec;
  logic              done;
  logic              rej;

  assign ch_off       = item_i.char_code - CHAR_A;
  assign is_letter    = (item_i.char_code >= CHAR_A) && (item_i.char_code < CHAR_END);
  assign glyph_new    = mtk_glyph(ch_off[IDX_W-1:0]);
  assign glyph_cur    = mtk_glyph(letter_q);
  assign elem_periods = glyph_cur[pos_q] ? cfg_i.dash_periods : cfg_i.dot_periods;
  assign half_inc     = half_q + 16'd1;
  assign per_inc      = per_q + 16'd1;
  assign gap_dec      = (gap_q != '0) ? gap_q - 20'd1 : gap_q;

  always_comb begin
    phase_d  = phase_q;
    letter_d = letter_q;
    pos_d    = pos_q;
    half_d   = half_q;
    per_d    = per_q;
    gap_d    = gap_q;
    pin_d    = pin_q;
    final_d  = final_q;
    done     = 1'b0;
    rej      = 1'b0;
    if (item_i.req_type) begin
      if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else if (is_letter) begin
        letter_d = ch_off[IDX_W-1:0];
        pos_d    = glyph_new[7:5] - 3'd1;
        final_d  = (glyph_new[7:5] == 3'd1);
        phase_d  = PH_WAIT;
      end else begin
        final_d = 1'b1;
        gap_d   = cfg_i.letter_gap;
        phase_d = PH_GAP;
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_WAIT: begin
          if (item_i.enabled) begin
            final_d = (pos_q == 3'd0);
            half_d  = '0;
            per_d   = '0;
            pin_d   = 1'b1;
            phase_d = PH_TONE;
          end
        end
        PH_TONE: begin
          half_d = half_inc;
          if (half_inc >= cfg_i.tone_half_period) begin
            half_d = '0;
            if (pin_q) begin
              pin_d = 1'b0;
            end else begin
              per_d = per_inc;
              if (per_inc >= elem_periods) begin
                gap_d   = final_q ? cfg_i.letter_gap : cfg_i.element_gap;
                phase_d = PH_GAP;
              end else begin
                pin_d = 1'b1;
              end
            end
          end
        end
        PH_GAP: begin
          gap_d = gap_dec;
          if (gap_dec == '0) begin
            if (final_q) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              pos_d   = pos_q - 3'd1;
              phase_d = PH_WAIT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      letter_q <= '0;
      pos_q    <= '0;
      half_q   <= '0;
      per_q    <= '0;
      gap_q    <= '0;
      pin_q    <= 1'b0;
      final_q  <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      letter_q <= letter_d;
      pos_q    <= pos_d;
      half_q   <= half_d;
      per_q    <= per_d;
      gap_q    <= gap_d;
      pin_q    <= pin_d;
      final_q  <= final_d;
    end
  end

  assign res_o.speaker   = pin_d;
  assign res_o.busy_res  = (phase_d != PH_IDLE);
  assign res_o.char_done = done;
  assign res_o.rejected  = rej;

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) || (phase_q == PH_WAIT) |-> !pin_q)
    else $error("speaker high outside a tone");

  a_gap_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GAP) |-> !pin_q)
    else $error("speaker high during a gap");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.req_type && (phase_q != PH_IDLE) |=> $stable(phase_q))
    else $error("rejected character changed the phase");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> (phase_q == PH_IDLE))
    else $error("character done without returning to idle");

endmodule

`default_nettype wire

[design/morse_tone_keyer_unit.sv]
// Top level of the Morse tone keyer: input register, keyer core, result register.
//
// Channels: in_i carries one transaction per microsecond tick (req_type 0) or
// per submitted character (req_type 1); out_o returns exactly one result per
// input transaction, in order; cfg_i writes the five timing registers by index
// and is always ready (indexes past the last register are ignored).
// Path: a transaction taken on in_i is held in the input register, and its result
// then in the result register, from which out_o presents it as valid.
// Throughput: one transaction per cycle while out_o is taken; the keyer state
// advances once per transaction, so a tick stream at clock rate runs unbroken.
// Stall: while out_o is not taken the result register holds, the input
// register fills and then in_i.ready drops; no transaction is lost.
// Reset: registers return to their defaults, the keyer goes idle with the
// speaker low, and both pipeline registers are emptied.

`default_nettype none

module morse_tone_keyer_unit
  import mtk_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mtk_in_if.sink     in_i,
  mtk_out_if.source  out_o,
  mtk_cfg_if.sink    cfg_i
);

  cfg_t  cfg;
  logic  in_valid_q;
  item_t in_item_q;
  logic  out_valid_q;
  res_t  out_res_q;
  res_t  core_res;
  logic  advance;
  logic  in_take;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.req_type  <= in_i.req_type;
      in_item_q.char_code <= in_i.char_code;
      in_item_q.enabled   <= in_i.enabled;
    end
  end

  mtk_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mtk_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (in_item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.speaker   = out_res_q.speaker;
  assign out_o.busy_res  = out_res_q.busy_res;
  assign out_o.char_done = out_res_q.char_done;
  assign out_o.rejected  = out_res_q.rejected;

endmodule

`default_nettype wire
